// ----- rtl/core/can_btc_pkg.sv -----
`default_nettype none

package can_btc_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RATE_ZERO = 2'd1;
  localparam logic [1:0] ST_PSC_RANGE = 2'd2;

  // Quanta search range and timing constants
  localparam logic [4:0]  QUANTA_MAX        = 5'd18;
  localparam logic [4:0]  QUANTA_LAST_TRIAL = 5'd10;
  localparam logic [4:0]  QUANTA_MIN        = 5'd9;
  localparam logic [10:0] PRESCALER_MAX     = 11'd1024;
  localparam logic [7:0]  SJW_FIELD         = 8'd1;   // jump width 2, stored minus one

  // Divider step counts: wide mode retires one quotient bit a cycle,
  // narrow mode (divisor of at most five bits) retires four.
  localparam int         DIV_W        = 32;
  localparam int         NARROW_BITS  = 4;
  localparam logic [5:0] WIDE_STEPS   = 6'd32;
  localparam logic [5:0] NARROW_STEPS = 6'd8;

  // Command from the sequencer to the shared divider
  typedef struct packed {
    logic start;
    logic wide;
  } div_cmd_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/can_btc_div.sv -----
`default_nettype none

// Shared restoring divider. Wide mode: 32-bit by 32-bit, one bit a cycle.
// Narrow mode: 32-bit by a divisor below 32, four bits a cycle.
module can_btc_div
  import can_btc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_cmd_t          cmd,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output div_stat_t              stat,
  output logic [DIV_W-1:0]       quotient,
  output logic [DIV_W-1:0]       remainder
);

  logic [DIV_W-1:0] dvd_r, dvd_nxt;   // dividend shifts out, quotient shifts in
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsr_r;
  logic             wide_r;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // Wide step
  logic [DIV_W:0]   w_shift;
  logic [DIV_W:0]   w_diff;

  // Narrow steps
  logic [4:0]             n_rem;
  logic [5:0]             n_trial;
  logic [NARROW_BITS-1:0] n_qbits;

  always_comb begin
    w_shift = {rem_r, dvd_r[DIV_W-1]};
    w_diff  = w_shift - {1'b0, dsr_r};
  end

  always_comb begin
    n_rem   = rem_r[4:0];
    n_qbits = '0;
    n_trial = '0;
    for (int i = 0; i < NARROW_BITS; i++) begin
      n_trial = {n_rem, dvd_r[DIV_W-1-i]};
      if (n_trial >= {1'b0, dsr_r[4:0]}) begin
        n_rem                      = 5'(n_trial - {1'b0, dsr_r[4:0]});
        n_qbits[NARROW_BITS-1-i]   = 1'b1;
      end else begin
        n_rem = n_trial[4:0];
      end
    end
  end

  // Step sequencing
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (wide_r) begin
        if (!w_diff[DIV_W]) begin
          rem_nxt = w_diff[DIV_W-1:0];
        end else begin
          rem_nxt = w_shift[DIV_W-1:0];
        end
        dvd_nxt = {dvd_r[DIV_W-2:0], ~w_diff[DIV_W]};
      end else begin
        rem_nxt = {{(DIV_W-5){1'b0}}, n_rem};
        dvd_nxt = {dvd_r[DIV_W-NARROW_BITS-1:0], n_qbits};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (cmd.start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = cmd.wide ? WIDE_STEPS : NARROW_STEPS;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (!busy_r && cmd.start) begin
      dsr_r  <= divisor;
      wide_r <= cmd.wide;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/can_bit_timing_calculator.sv -----
// CAN bit timing calculator: takes one (clock_hz, bit_rate) item, divides them
// into clocks per bit, searches quanta per bit from 18 down to 10 for an exact
// divisor (9 if none), and returns prescaler, quanta, status and the packed
// timing word as one result item. All arithmetic runs through one shared
// restoring divider: the clocks-per-bit division runs one bit a cycle and
// each quanta trial runs four bits a cycle, and an item ends either at the
// first exact divisor or, with no exact divisor, after the fallback division
// by 9; a zero bitrate is answered in the cycle after acceptance, without the
// divider. in_stall stays high from acceptance until the result is taken.
`default_nettype none

module can_bit_timing_calculator
  import can_btc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_clock_hz,
  input  wire logic [31:0] in_bit_rate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_timing_word,
  output logic [10:0]      out_prescaler,
  output logic [4:0]       out_quanta_per_bit,
  output logic [1:0]       out_status
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_TRIAL = 5'b00100,
    S_FINAL = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  quanta_r, quanta_nxt;
  logic [31:0] bit_ticks_r, bit_ticks_nxt;
  logic [31:0] word_r, word_nxt;
  logic [10:0] psc_r, psc_nxt;
  logic [1:0]  status_r, status_nxt;

  div_cmd_t    div_cmd;
  div_stat_t   div_stat;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic [31:0] div_quot;
  logic [31:0] div_rem;

  logic        in_acc;
  logic        finish;
  logic [4:0]  ts2;
  logic [4:0]  ts1;

  can_btc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (div_cmd),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_acc = in_valid && !in_stall;

  // Segment split for the chosen quanta
  assign ts2 = quanta_r >> 3;
  assign ts1 = quanta_r - 5'd1 - ts2;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    quanta_nxt     = quanta_r;
    bit_ticks_nxt  = bit_ticks_r;
    word_nxt       = word_r;
    psc_nxt        = psc_r;
    status_nxt     = status_r;
    div_cmd        = '0;
    div_dividend   = bit_ticks_r;
    div_divisor    = {27'd0, quanta_r};
    finish         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_bit_rate == 32'd0) begin
            word_nxt   = '0;
            psc_nxt    = '0;
            quanta_nxt = QUANTA_MIN;
            status_nxt = ST_RATE_ZERO;
            state_nxt  = S_OUT;
          end else begin
            div_cmd.start = 1'b1;
            div_cmd.wide  = 1'b1;
            div_dividend  = in_clock_hz;
            div_divisor   = in_bit_rate;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          bit_ticks_nxt  = div_quot;
          quanta_nxt     = QUANTA_MAX;
          div_cmd.start  = 1'b1;
          div_dividend   = div_quot;
          div_divisor    = {27'd0, QUANTA_MAX};
          state_nxt      = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (div_stat.done) begin
          if (div_rem == 32'd0) begin
            finish = 1'b1;
          end else begin
            quanta_nxt    = (quanta_r == QUANTA_LAST_TRIAL) ? QUANTA_MIN
                                                            : quanta_r - 5'd1;
            div_cmd.start = 1'b1;
            div_divisor   = {27'd0, quanta_nxt};
            if (quanta_r == QUANTA_LAST_TRIAL) begin
              state_nxt = S_FINAL;
            end
          end
        end
      end
      S_FINAL: begin
        if (div_stat.done) begin
          finish = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Range check of the prescaler and packing of the timing word
    if (finish) begin
      state_nxt = S_OUT;
      if (div_quot == 32'd0) begin
        status_nxt = ST_PSC_RANGE;
        psc_nxt    = '0;
        word_nxt   = '0;
      end else if (div_quot > {21'd0, PRESCALER_MAX}) begin
        status_nxt = ST_PSC_RANGE;
        psc_nxt    = PRESCALER_MAX;
        word_nxt   = '0;
      end else begin
        status_nxt = ST_OK;
        psc_nxt    = div_quot[10:0];
        word_nxt   = {SJW_FIELD, 4'(ts2 - 5'd1), 4'(ts1 - 5'd1),
                      16'(div_quot - 32'd1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    quanta_r     <= quanta_nxt;
    bit_ticks_r  <= bit_ticks_nxt;
    word_r       <= word_nxt;
    psc_r        <= psc_nxt;
    status_r     <= status_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_timing_word    = word_r;
  assign out_prescaler      = psc_r;
  assign out_quanta_per_bit = quanta_r;
  assign out_status         = status_r;

endmodule

`default_nettype wire

// ----- rtl/core/can_btc_checker.sv -----
`default_nettype none

module can_btc_checker
  import can_btc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_timing_word,
  input wire logic [10:0] out_prescaler,
  input wire logic [4:0]  out_quanta_per_bit,
  input wire logic [1:0]  out_status
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An accepted item blocks further input until its result leaves
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // Good results carry an in-range prescaler and quanta and a matching low field
  a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_prescaler != 11'd0 && out_prescaler <= PRESCALER_MAX &&
      out_timing_word[15:0] == 16'(out_prescaler - 11'd1) &&
      out_quanta_per_bit >= QUANTA_MIN && out_quanta_per_bit <= QUANTA_MAX)
    else $error("bad prescaler or quanta on a good result");

  // Error results carry a zero word and a known error status
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_timing_word == 32'd0 &&
      (out_status == ST_RATE_ZERO || out_status == ST_PSC_RANGE))
    else $error("error result with nonzero timing word");

endmodule

bind can_bit_timing_calculator can_btc_checker u_can_btc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_timing_word    (out_timing_word),
  .out_prescaler      (out_prescaler),
  .out_quanta_per_bit (out_quanta_per_bit),
  .out_status         (out_status)
);

`default_nettype wire
